@@ src/pfc_pkg.sv @@
// shared types, constants and the checksum step for the packet frame checker
`timescale 1ns / 1ps

package pfc_pkg;

   // checksum step constants
   localparam logic [15:0] SUM_ADD   = 16'd10000;
   localparam logic [15:0] SUM_XOR   = 16'h5AA5;
   localparam int unsigned SUM_SHIFT = 7;

   // frame parse phases
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CK_HI   = 3'd1,
      PH_LEN     = 3'd2,
      PH_TAG_LO  = 3'd3,
      PH_TAG_HI  = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   // one result transfer
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        frame_done;
      logic        checksum_ok;
      logic [15:0] header_checksum;
      logic [15:0] channel_tag;
      logic [7:0]  payload_length;
   } result_type;

   // one running checksum update over a payload byte
   function automatic logic [15:0] sum_step(input logic [15:0] sum, input logic [7:0] b);
      logic [15:0] mixed;
      logic [15:0] total;
      mixed = (16'(b) << SUM_SHIFT) | 16'(b);
      total = sum + mixed + SUM_ADD;
      return total ^ SUM_XOR;
   endfunction

endpackage

@@ src/packet_frame_checker.sv @@
// top level of the packet frame checker: input register, parser and result register
`timescale 1ns / 1ps

// The checker takes one received frame byte per cycle while req_stall is low and
// returns one result per byte, after the byte passes through the input register
// and then the result register. Throughput is one byte per clock while the
// pipeline is not stalled, set by the parser state update. The input side stalls
// only when both the input register and the result register are full and the
// result is itself stalled.

module packet_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_frame_done,
   output logic        rsp_checksum_ok,
   output logic [15:0] rsp_header_checksum,
   output logic [15:0] rsp_channel_tag,
   output logic [7:0]  rsp_payload_length
);
   import pfc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   result_type parse_result;
   logic       out_free;
   logic       advance;
   logic       req_take;

   // pipeline flow
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   // parser
   pfc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .result      (parse_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= parse_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_payload_byte    = out_data_ff.payload_byte;
   assign rsp_payload_valid   = out_data_ff.payload_valid;
   assign rsp_frame_done      = out_data_ff.frame_done;
   assign rsp_checksum_ok     = out_data_ff.checksum_ok;
   assign rsp_header_checksum = out_data_ff.header_checksum;
   assign rsp_channel_tag     = out_data_ff.channel_tag;
   assign rsp_payload_length  = out_data_ff.payload_length;

   // checks
   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_checksum_ok) |-> rsp_frame_done)
      else $error("checksum_ok without frame_done");

   a_empty_frame_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done && !rsp_payload_valid) |-> (rsp_payload_length == 8'd0))
      else $error("header-only completion with nonzero length");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> !advance || !$past(in_valid_ff) || out_valid_ff)
      else $error("stalled result dropped");

endmodule

@@ src/pfc_parser.sv @@
// frame parser: header capture, payload checksum and completion flags
`timescale 1ns / 1ps

module pfc_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   input  logic               frame_start,
   output pfc_pkg::result_type result
);
   import pfc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] held_ck_ff, held_ck_in;
   logic [15:0] held_tag_ff, held_tag_in;
   logic [7:0]  held_len_ff, held_len_in;

   // state registers, updated once per byte taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= '0;
         sum_ff        <= '0;
         held_ck_ff    <= '0;
         held_tag_ff   <= '0;
         held_len_ff   <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
         held_ck_ff    <= held_ck_in;
         held_tag_ff   <= held_tag_in;
         held_len_ff   <= held_len_in;
      end
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      held_ck_in    = held_ck_ff;
      held_tag_in   = held_tag_ff;
      held_len_in   = held_len_ff;
      if (frame_start) begin
         held_ck_in    = 16'(rx_byte);
         held_tag_in   = '0;
         held_len_in   = '0;
         sum_in        = '0;
         bytes_left_in = '0;
         phase_in      = PH_CK_HI;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_CK_HI: begin
               held_ck_in = {rx_byte, held_ck_ff[7:0]};
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               held_len_in   = rx_byte;
               bytes_left_in = rx_byte;
               phase_in      = PH_TAG_LO;
            end
            PH_TAG_LO: begin
               held_tag_in = 16'(rx_byte);
               phase_in    = PH_TAG_HI;
            end
            PH_TAG_HI: begin
               held_tag_in = {rx_byte, held_tag_ff[7:0]};
               phase_in    = (bytes_left_ff == '0) ? PH_IDLE : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               sum_in        = sum_step(sum_ff, rx_byte);
               bytes_left_in = bytes_left_ff - 8'd1;
               phase_in      = (bytes_left_in == '0) ? PH_IDLE : PH_PAYLOAD;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // result fields for this byte
   always_comb begin
      result                 = '0;
      result.header_checksum = held_ck_in;
      result.channel_tag     = held_tag_in;
      result.payload_length  = held_len_in;
      if (!frame_start) begin
         case (phase_ff)
            PH_TAG_HI: begin
               if (bytes_left_ff == '0) begin
                  result.frame_done  = 1'b1;
                  result.checksum_ok = (sum_ff == held_ck_ff);
               end
            end
            PH_PAYLOAD: begin
               result.payload_byte  = rx_byte;
               result.payload_valid = 1'b1;
               if (bytes_left_in == '0) begin
                  result.frame_done  = 1'b1;
                  result.checksum_ok = (sum_in == held_ck_ff);
               end
            end
            default: begin
               result.frame_done = 1'b0;
            end
         endcase
      end
   end

endmodule
